// ===== rtl/ltl_pkg.sv =====
package ltl_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int FIFO_DEPTH      = 4;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_IDENT   = 2'd1,
    MODE_INT     = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_t;

  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_INT    = 3'd1;
  localparam logic [2:0] KIND_LPAREN = 3'd2;
  localparam logic [2:0] KIND_RPAREN = 3'd3;
  localparam logic [2:0] KIND_LAMBDA = 3'd4;
  localparam logic [2:0] KIND_DOT    = 3'd5;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_DOT       = 8'h2e;
  localparam logic [7:0] CH_SEMICOLON = 8'h3b;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  typedef struct packed {
    logic empty;
    logic room2;
  } fifo_stat_t;

endpackage

// ===== rtl/ltl_if.sv =====
interface ltl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source(output valid, output byte_value, output last_byte, input ready);
  modport sink(input valid, input byte_value, input last_byte, output ready);
endinterface

interface ltl_out_if #(
  parameter int COUNT_WIDTH = ltl_pkg::COUNT_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             token_code;
  logic [COUNT_WIDTH-1:0] token_start;
  logic [COUNT_WIDTH-1:0] token_length;
  logic [COUNT_WIDTH-1:0] token_line;
  logic [COUNT_WIDTH-1:0] token_column;
  logic                   end_of_run;

  modport source(output valid, output token_code, output token_start, output token_length,
                 output token_line, output token_column, output end_of_run, input ready);
  modport sink(input valid, input token_code, input token_start, input token_length,
               input token_line, input token_column, input end_of_run, output ready);
endinterface

// ===== rtl/ltl_scan.sv =====
module ltl_scan #(
  parameter int COUNT_WIDTH = ltl_pkg::COUNT_WIDTH_DEF,
  localparam int TOK_W = 4 + 4 * COUNT_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       byte_value,
  input  logic             last_byte,
  output logic [1:0]       push_n,
  output logic [TOK_W-1:0] tok_a,
  output logic [TOK_W-1:0] tok_b
);
  import ltl_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] ONE = CW'(1);

  typedef struct packed {
    logic [2:0]    kind;
    logic [CW-1:0] start;
    logic [CW-1:0] length;
    logic [CW-1:0] line;
    logic [CW-1:0] column;
    logic          eor;
  } tok_t;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (&v) ? v : v + ONE;
  endfunction

  mode_t         mode_r, mode_nxt;
  logic          pk_r, pk_nxt;
  logic [CW-1:0] ps_r, ps_nxt;
  logic [CW-1:0] pl_r, pl_nxt;
  logic [CW-1:0] pln_r, pln_nxt;
  logic [CW-1:0] pc_r, pc_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] line_r, line_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic       is_nl, is_sp, is_dig, ends_id;
  logic       at_start, emit_pend, emit_one, flush;
  logic [2:0] one_kind;
  logic [1:0] cnt;
  tok_t       tp, ts, tf, ta, tb;

  always_comb begin
    is_nl   = (byte_value == CH_NEWLINE);
    is_sp   = is_nl || (byte_value == CH_SPACE) || (byte_value == CH_TAB);
    is_dig  = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
    ends_id = is_sp || (byte_value == CH_LPAREN) || (byte_value == CH_RPAREN) ||
              (byte_value == CH_BACKSLASH) || (byte_value == CH_DOT) ||
              (byte_value == CH_SEMICOLON);

    mode_nxt  = mode_r;
    pk_nxt    = pk_r;
    ps_nxt    = ps_r;
    pl_nxt    = pl_r;
    pln_nxt   = pln_r;
    pc_nxt    = pc_r;
    at_start  = 1'b0;
    emit_pend = 1'b0;
    emit_one  = 1'b0;
    one_kind  = KIND_LPAREN;

    unique case (mode_r)
      MODE_IDENT: begin
        if (ends_id) begin
          emit_pend = 1'b1;
          mode_nxt  = MODE_START;
          at_start  = 1'b1;
        end else begin
          pl_nxt = sat_inc(pl_r);
        end
      end
      MODE_INT: begin
        if (is_dig) begin
          pl_nxt = sat_inc(pl_r);
        end else begin
          emit_pend = 1'b1;
          mode_nxt  = MODE_START;
          at_start  = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (is_nl) begin
          mode_nxt = MODE_START;
        end
      end
      default: begin
        at_start = 1'b1;
      end
    endcase

    if (at_start && !is_sp) begin
      if (is_dig || !ends_id) begin
        pk_nxt   = is_dig;
        ps_nxt   = pos_r;
        pl_nxt   = ONE;
        pln_nxt  = line_r;
        pc_nxt   = col_r;
        mode_nxt = is_dig ? MODE_INT : MODE_IDENT;
      end else if (byte_value == CH_SEMICOLON) begin
        mode_nxt = MODE_COMMENT;
      end else begin
        emit_one = 1'b1;
        if (byte_value == CH_LPAREN) begin
          one_kind = KIND_LPAREN;
        end else if (byte_value == CH_RPAREN) begin
          one_kind = KIND_RPAREN;
        end else if (byte_value == CH_BACKSLASH) begin
          one_kind = KIND_LAMBDA;
        end else begin
          one_kind = KIND_DOT;
        end
      end
    end

    if (is_nl) begin
      line_nxt = sat_inc(line_r);
      col_nxt  = ONE;
    end else begin
      line_nxt = line_r;
      col_nxt  = sat_inc(col_r);
    end
    pos_nxt = sat_inc(pos_r);

    flush = last_byte && ((mode_nxt == MODE_IDENT) || (mode_nxt == MODE_INT));

    tp = '{kind: (pk_r ? KIND_INT : KIND_IDENT), start: ps_r, length: pl_r,
           line: pln_r, column: pc_r, eor: 1'b0};
    ts = '{kind: one_kind, start: pos_r, length: ONE, line: line_r, column: col_r,
           eor: 1'b0};
    tf = '{kind: (pk_nxt ? KIND_INT : KIND_IDENT), start: ps_nxt, length: pl_nxt,
           line: pln_nxt, column: pc_nxt, eor: 1'b0};

    cnt = {1'b0, emit_pend} + {1'b0, emit_one} + {1'b0, flush};
    ta = emit_pend ? tp : (emit_one ? ts : tf);
    ta.eor = (cnt == 2'd1);
    tb = emit_one ? ts : tf;
    tb.eor = 1'b1;

    if (last_byte) begin
      mode_nxt = MODE_START;
      pk_nxt   = 1'b0;
      ps_nxt   = '0;
      pl_nxt   = '0;
      pln_nxt  = ONE;
      pc_nxt   = ONE;
      pos_nxt  = '0;
      line_nxt = ONE;
      col_nxt  = ONE;
    end
  end

  assign push_n = accept ? cnt : 2'd0;
  assign tok_a  = ta;
  assign tok_b  = tb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
      pk_r   <= 1'b0;
      ps_r   <= '0;
      pl_r   <= '0;
      pln_r  <= ONE;
      pc_r   <= ONE;
      pos_r  <= '0;
      line_r <= ONE;
      col_r  <= ONE;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pk_r   <= pk_nxt;
      ps_r   <= ps_nxt;
      pl_r   <= pl_nxt;
      pln_r  <= pln_nxt;
      pc_r   <= pc_nxt;
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

// ===== rtl/ltl_tok_fifo.sv =====
module ltl_tok_fifo #(
  parameter int WIDTH = 68,
  parameter int DEPTH = ltl_pkg::FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  logic [WIDTH-1:0]    din_a,
  input  logic [WIDTH-1:0]    din_b,
  input  logic                pop,
  output logic [WIDTH-1:0]    dout,
  output ltl_pkg::fifo_stat_t stat
);
  import ltl_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r + PW'(push_n);
    rd_nxt  = rd_r + PW'(pop);
    cnt_nxt = cnt_r + NW'(push_n) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= din_a;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_r + PW'(1)] <= din_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign dout       = mem_r[rd_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.room2 = (cnt_r <= NW'(DEPTH - 2));

endmodule

// ===== rtl/lambda_term_lexer.sv =====
// A token is written into the four-entry token queue when the byte that ends it is taken;
// the result channel offers the queue head. The scanner takes one byte per cycle while the
// queue has room for two tokens, and updates its state in the cycle it takes a byte. A byte
// that yields two tokens writes both, and the queue drains one token per cycle on out_ch.ready.
// Reset (synchronous, active low) empties the queue and returns the scanner to line 1, column 1.
module lambda_term_lexer #(
  parameter int COUNT_WIDTH = ltl_pkg::COUNT_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ltl_in_if.sink     in_ch,
  ltl_out_if.source  out_ch
);
  import ltl_pkg::*;

  localparam int CW    = COUNT_WIDTH;
  localparam int TOK_W = 4 + 4 * CW;

  typedef struct packed {
    logic [2:0]    kind;
    logic [CW-1:0] start;
    logic [CW-1:0] length;
    logic [CW-1:0] line;
    logic [CW-1:0] column;
    logic          eor;
  } tok_t;

  logic             in_fire, out_fire;
  logic [1:0]       push_n;
  logic [TOK_W-1:0] tok_a, tok_b, tok_q;
  fifo_stat_t       stat;
  tok_t             head;

  assign in_ch.ready = stat.room2;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  ltl_scan #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_fire),
    .byte_value(in_ch.byte_value),
    .last_byte (in_ch.last_byte),
    .push_n    (push_n),
    .tok_a     (tok_a),
    .tok_b     (tok_b)
  );

  ltl_tok_fifo #(
    .WIDTH(TOK_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push_n(push_n),
    .din_a (tok_a),
    .din_b (tok_b),
    .pop   (out_fire),
    .dout  (tok_q),
    .stat  (stat)
  );

  assign head                = tok_t'(tok_q);
  assign out_ch.valid        = !stat.empty;
  assign out_ch.token_code   = head.kind;
  assign out_ch.token_start  = head.start;
  assign out_ch.token_length = head.length;
  assign out_ch.token_line   = head.line;
  assign out_ch.token_column = head.column;
  assign out_ch.end_of_run   = head.eor;

  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |-> push_n == 2'd0)
    else $error("tokens pushed without an accepted request");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && push_n != 2'd0 |=> out_ch.valid)
    else $error("pushed token not offered");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.room2 |-> !stat.empty)
    else $error("queue reports no room while empty");

  a_valid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(in_fire))
    else $error("result appeared without an accepted request");

endmodule
